// File: hw/rtl/base64url_stream_encoder_defines.svh
// Assertion macros shared by the encoder checker.
`ifndef BASE64URL_STREAM_ENCODER_DEFINES_SVH
`define BASE64URL_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B64U_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("encoder check failed");

// Next-cycle implication, disabled during reset.
`define B64U_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("encoder check failed");

`endif

// File: hw/rtl/b64u_pkg.sv
// Shared types, constants and the alphabet lookup for the base64url encoder.
`timescale 1ns / 1ps

package b64u_pkg;

   // Decoupling queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Position within the 3-byte group.
   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   typedef logic [5:0] sextet_type;
   typedef logic [6:0] ascii_type;

   // Work for one byte: one or two sextets, last flag on the final one.
   typedef struct packed {
      sextet_type c0;
      sextet_type c1;
      logic       two;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // URL-safe alphabet: A-Z, a-z, 0-9, '-', '_'.
   function automatic ascii_type to_ascii(input sextet_type v);
      ascii_type r;
      if (v < 6'd26) begin
         r = {1'b0, v} + 7'd65;
      end else if (v < 6'd52) begin
         r = {1'b0, v} + 7'd71;
      end else if (v < 6'd62) begin
         r = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
         r = 7'd45;
      end else begin
         r = 7'd95;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/b64u_if.sv
// Request and response channel interfaces of the base64url encoder.
`timescale 1ns / 1ps

interface b64u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64u_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] code_char;
   logic       last_char;

   modport source (output valid, output code_char, output last_char, input ready);
   modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

// File: hw/rtl/b64u_front.sv
// Front end: accepts bytes, tracks group phase and leftover bits, builds sextets.
`timescale 1ns / 1ps

module b64u_front (
   input  logic                 clock,
   input  logic                 reset,
   b64u_req_if.sink             req,
   input  b64u_pkg::qstat_type  qstat,
   output logic                 push,
   output b64u_pkg::entry_type  push_entry
);

   logic [3:0] kept_ff, kept_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] b;
   logic       eom;

   assign b         = req.data_byte;
   assign eom       = req.end_of_message;
   assign req.ready = !qstat.full;
   assign push      = req.valid && !qstat.full;

   // Split the byte per phase; a final byte flushes leftover bits.
   always_comb begin
      push_entry = '0;
      kept_in    = kept_ff;
      phase_in   = phase_ff;
      case (phase_ff)
         b64u_pkg::PHASE_1: begin
            push_entry.c0   = {kept_ff[1:0], b[7:4]};
            push_entry.c1   = {b[3:0], 2'b00};
            push_entry.two  = eom;
            push_entry.last = eom;
            kept_in         = eom ? 4'd0 : b[3:0];
            phase_in        = eom ? b64u_pkg::PHASE_0 : b64u_pkg::PHASE_2;
         end
         b64u_pkg::PHASE_2: begin
            push_entry.c0   = {kept_ff, b[7:6]};
            push_entry.c1   = b[5:0];
            push_entry.two  = 1'b1;
            push_entry.last = eom;
            kept_in         = 4'd0;
            phase_in        = b64u_pkg::PHASE_0;
         end
         default: begin
            // phase 0, and the unreachable code 3 treated alike
            push_entry.c0   = b[7:2];
            push_entry.c1   = {b[1:0], 4'b0000};
            push_entry.two  = eom;
            push_entry.last = eom;
            kept_in         = eom ? 4'd0 : {2'b00, b[1:0]};
            phase_in        = eom ? b64u_pkg::PHASE_0 : b64u_pkg::PHASE_1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff  <= 4'd0;
         phase_ff <= b64u_pkg::PHASE_0;
      end else if (push) begin
         kept_ff  <= kept_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: hw/rtl/b64u_queue.sv
// Short FIFO of byte work entries between front and back.
`timescale 1ns / 1ps

module b64u_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64u_pkg::entry_type  push_entry,
   input  logic                 pop,
   output b64u_pkg::entry_type  head_entry,
   output b64u_pkg::qstat_type  qstat
);

   b64u_pkg::entry_type              mem_ff [b64u_pkg::QUEUE_DEPTH];
   logic [b64u_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [b64u_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [b64u_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                             do_push, do_pop;

   assign qstat.full  = (cnt_ff == b64u_pkg::QCNT_W'(b64u_pkg::QUEUE_DEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_entry  = mem_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == b64u_pkg::QPTR_W'(b64u_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == b64u_pkg::QPTR_W'(b64u_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage, no reset needed.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/b64u_back.sv
// Back end: drains entries one character per cycle, while the output is not stalled, into the output register.
`timescale 1ns / 1ps

module b64u_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64u_pkg::qstat_type  qstat,
   input  b64u_pkg::entry_type  head_entry,
   output logic                 pop,
   b64u_rsp_if.source           rsp
);

   logic                   sel_ff, sel_in;
   logic                   valid_ff, valid_in;
   b64u_pkg::ascii_type    char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   out_free, load;
   b64u_pkg::sextet_type   code;

   assign rsp.valid     = valid_ff;
   assign rsp.code_char = char_ff;
   assign rsp.last_char = last_ff;

   assign out_free = !valid_ff || rsp.ready;
   assign load     = out_free && !qstat.empty;
   assign code     = sel_ff ? head_entry.c1 : head_entry.c0;
   // The entry retires on its last character.
   assign pop      = load && (sel_ff || !head_entry.two);

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = b64u_pkg::to_ascii(code);
         last_in  = sel_ff && head_entry.last;
         sel_in   = head_entry.two && !sel_ff;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

// File: hw/rtl/base64url_stream_encoder.sv
// Top level of the unpadded URL-safe base64 stream encoder.
// One raw byte per request, end_of_message on the final byte of a message;
// one ASCII character per response from A-Z a-z 0-9 '-' '_', last_char on
// the final character, no '=' padding. A byte yields one or two characters,
// and the response register delivers one character per cycle while the
// response is not stalled. A two-entry queue between the byte front end and
// the character back end lets requests keep arriving while a response is
// stalled; the request side stalls only when that queue is full. A request's
// first character passes through a queue entry and then the response register.
`timescale 1ns / 1ps

module base64url_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   b64u_req_if.sink   req_ch,
   b64u_rsp_if.source rsp_ch
);

   b64u_pkg::qstat_type qstat;
   b64u_pkg::entry_type push_entry, head_entry;
   logic                push, pop;

   b64u_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   b64u_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .qstat      (qstat)
   );

   b64u_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

// File: hw/rtl/b64u_checker.sv
// Port-level checker for the base64url encoder and its bind.
`timescale 1ns / 1ps
`include "base64url_stream_encoder_defines.svh"

module b64u_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_code_char,
   input logic       rsp_last_char
);

   logic in_alphabet;

   // Characters come only from the URL-safe alphabet.
   assign in_alphabet = (rsp_code_char == 7'd45) || (rsp_code_char == 7'd95)
                     || ((rsp_code_char >= 7'd48) && (rsp_code_char <= 7'd57))
                     || ((rsp_code_char >= 7'd65) && (rsp_code_char <= 7'd90))
                     || ((rsp_code_char >= 7'd97) && (rsp_code_char <= 7'd122));

   `B64U_ASSERT_NOW(a_alphabet, clock, reset, rsp_valid, in_alphabet)

   // Coming out of reset: nothing pending, ready to take a request.
   `B64U_ASSERT_NOW(a_reset_idle, clock, reset, $past(reset), !rsp_valid && req_ready)

   // A stalled response holds.
   `B64U_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_code_char) && $stable(rsp_last_char))

   // A request taken in the first cycle after reset leaves room for the next.
   `B64U_ASSERT_NEXT(a_no_early_stall, clock, reset,
                     $past(reset) && req_valid && !rsp_valid, req_ready)

endmodule

bind base64url_stream_encoder b64u_checker u_b64u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_code_char (rsp_ch.code_char),
   .rsp_last_char (rsp_ch.last_char)
);

// File: tb/sv/base64url_stream_encoder_tb.sv
// Self-checking testbench for the base64url stream encoder.
`timescale 1ns / 1ps

module base64url_stream_encoder_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 12;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      b64u_pkg::ascii_type code;
      logic                last;
   } encoded_char_type;

   logic clock = 1'b0;
   logic reset;

   b64u_req_if req_bus ();
   b64u_rsp_if rsp_bus ();

   base64url_stream_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Encoder shadow state and characters still owed by the block
   string            url_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
   logic [3:0]       kept_bits;
   logic [1:0]       byte_phase;
   encoded_char_type pending_chars[$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   bit               steady_run     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("base64url_stream_encoder_tb: done, errors");
         $finish;
      end
   end

   function automatic bit take_break();
      return !steady_run && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   task automatic enqueue_char(input b64u_pkg::sextet_type value, input logic last);
      byte              ch;
      encoded_char_type item;
      ch        = url_alphabet[value];
      item.code = ch[6:0];
      item.last = last;
      pending_chars.insert(pending_chars.size(), item);
   endtask

   // Expected characters for one accepted byte
   task automatic encode_byte(input logic [7:0] data, input logic eom);
      case (byte_phase)
         b64u_pkg::PHASE_1: begin
            enqueue_char({kept_bits[1:0], data[7:4]}, 1'b0);
            kept_bits  = data[3:0];
            byte_phase = b64u_pkg::PHASE_2;
         end
         b64u_pkg::PHASE_2: begin
            enqueue_char({kept_bits, data[7:6]}, 1'b0);
            enqueue_char(data[5:0], eom);
            kept_bits  = 4'd0;
            byte_phase = b64u_pkg::PHASE_0;
         end
         default: begin
            enqueue_char(data[7:2], 1'b0);
            kept_bits  = {2'b00, data[1:0]};
            byte_phase = b64u_pkg::PHASE_1;
         end
      endcase
      // flush partial group at end of message
      if (eom) begin
         if (byte_phase == b64u_pkg::PHASE_1) begin
            enqueue_char({kept_bits[1:0], 4'd0}, 1'b1);
         end else if (byte_phase == b64u_pkg::PHASE_2) begin
            enqueue_char({kept_bits, 2'b00}, 1'b1);
         end
         kept_bits  = 4'd0;
         byte_phase = b64u_pkg::PHASE_0;
      end
   endtask

   // Response checker and random backpressure
   always @(posedge clock) begin
      encoded_char_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                     $time, rsp_bus.code_char, rsp_bus.last_char);
            mismatch_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_bus.code_char !== want.code) begin
               $display("%0t: code_char mismatch: expected %0d, actual %0d",
                        $time, want.code, rsp_bus.code_char);
               mismatch_count++;
            end
            if (rsp_bus.last_char !== want.last) begin
               $display("%0t: last_char mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_bus.last_char);
               mismatch_count++;
            end
         end
      end
      rsp_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Send one request; returns on the edge it is accepted, valid left high
   task automatic send_byte(input logic [7:0] data, input logic eom);
      while (take_break()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= data;
      req_bus.end_of_message <= eom;
      do @(posedge clock); while (!req_bus.ready);
      encode_byte(data, eom);
   endtask

   task automatic wait_for_drain();
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input int length);
      for (int i = 0; i < length; i++) begin
         send_byte(8'($urandom_range(255)), i == length - 1);
      end
   endtask

   // Alphabet extremes and message ends in every phase
   task automatic test_directed();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h83, 1'b1);
      send_byte(8'h69, 1'b0);
      send_byte(8'hB7, 1'b0);
      send_byte(8'h1D, 1'b1);
      send_byte(8'hD3, 1'b0);
      send_byte(8'h5D, 1'b0);
      send_byte(8'hB7, 1'b1);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b1);
   endtask

   // Random messages, mostly short, a few long ones
   task automatic test_random_messages();
      int sent;
      int length;
      sent = 0;
      while (sent < 380) begin
         length = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         send_message(length);
         sent += length;
      end
   endtask

   // End marks at random, including back-to-back single-byte messages
   task automatic test_random_end_marks();
      for (int i = 0; i < 60; i++) begin
         send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   // Sender holds off until every owed character is out
   task automatic test_drain_pause();
      for (int round = 0; round < 3; round++) begin
         send_message($urandom_range(6, 1));
         req_bus.valid <= 1'b0;
         @(posedge clock);
         wait_for_drain();
      end
   endtask

   // Full rate on both sides with no idling
   task automatic test_full_rate();
      int sent;
      int length;
      sent       = 0;
      steady_run = 1'b1;
      while (sent < 60) begin
         length = $urandom_range(10, 1);
         send_message(length);
         sent += length;
      end
      steady_run = 1'b0;
   endtask

   initial begin
      kept_bits              = 4'd0;
      byte_phase             = b64u_pkg::PHASE_0;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.data_byte      = 8'd0;
      req_bus.end_of_message = 1'b0;
      rsp_bus.ready          = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_drain_pause();
      test_random_messages();
      test_full_rate();
      test_random_end_marks();

      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("base64url_stream_encoder_tb: done, clean");
      end else begin
         $display("base64url_stream_encoder_tb: done, errors");
      end
      $finish;
   end

endmodule
